[design/ssf_pkg.sv]
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared constants for the SPI serial-flash slave: flash geometry, command
// codes, item kinds and configuration register indexes.
// ----------------------------------------------------------------------------
package ssf_pkg;

  localparam int FLASH_ADDR_BITS = 18;
  localparam int FLASH_DEPTH     = 1 << FLASH_ADDR_BITS;
  localparam int ADDR_W          = 24;
  localparam int BYTE_W          = 8;

  localparam logic [BYTE_W-1:0] CMD_NONE = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_WR   = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_RD   = 8'h03;
  localparam logic [BYTE_W-1:0] CMD_WRDI = 8'h04;
  localparam logic [BYTE_W-1:0] CMD_RDSR = 8'h05;
  localparam logic [BYTE_W-1:0] CMD_WREN = 8'h06;

  localparam logic OP_XCHG = 1'b0;
  localparam logic OP_CTRL = 1'b1;

  localparam logic CFG_SPI_EN = 1'b0;
  localparam logic CFG_IRQ_EN = 1'b1;

  localparam logic [1:0] ADDR_BYTES = 2'd3;

endpackage

[design/ssf_ram.sv]
// ----------------------------------------------------------------------------
// ssf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/spi_serial_flash_slave_unit.sv]
// ----------------------------------------------------------------------------
// spi_serial_flash_slave_unit
// SPI serial-flash slave: command byte, 24-bit address phase, then WR/RD
// data bytes on a flash array, status read and write-enable latch handling.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | tuser: opcode; tdata: tx_byte, cs_hold
//   out_    | out | out_tvalid/tready  | tdata: rx_byte, irq
//   cfg_    | in  | cfg_we             | cfg_addr index, cfg_wdata value
//
// one item per cycle sustained while out_ does not stall; an item passes the
// input register, then the result register together with the flash read port
// after reset the whole flash is zeroed, one byte a cycle, with in_tready
// low; config writes are taken meanwhile
// an out_ stall holds the input register; in_tready follows out_tready
// control writes and disabled exchanges give no result item
// ----------------------------------------------------------------------------
module spi_serial_flash_slave_unit
  import ssf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] tx_byte, [8] cs_hold
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] rx_byte, [8] irq
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic        cfg_wdata
);

  localparam int FA = FLASH_ADDR_BITS;

  logic spi_en_r, irq_en_r;

  logic              s1_valid_r;
  logic              s1_op_r;
  logic [BYTE_W-1:0] s1_tx_r;
  logic              s1_hold_r;

  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [1:0]        left_r, left_nxt;
  logic              wel_r, wel_nxt;
  logic              hold_r, hold_nxt;

  logic              clr_busy_r;
  logic [FA-1:0]     clr_addr_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] rx_r;
  logic              rd_sel_r;
  logic              irq_r;

  logic              out_free, s1_fire;
  logic              res_valid, res_rd, wr_hit;
  logic [BYTE_W-1:0] res_rx;
  logic [FA-1:0]     flash_idx, idx_inc;
  logic              ram_we, ram_re;
  logic [FA-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  assign out_free  = ~out_valid_r | out_tready;
  assign s1_fire   = s1_valid_r & out_free;
  assign in_tready = ~clr_busy_r & (~s1_valid_r | out_free);

  assign flash_idx = addr_r[FA-1:0];
  assign idx_inc   = flash_idx + 1'b1;

  // command handling for the item in the input register
  always_comb begin
    cmd_nxt   = cmd_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    wel_nxt   = wel_r;
    hold_nxt  = hold_r;
    res_valid = 1'b0;
    res_rd    = 1'b0;
    res_rx    = '0;
    wr_hit    = 1'b0;
    if (s1_op_r == OP_CTRL) begin
      if (!hold_r) begin
        cmd_nxt = CMD_NONE;
      end
      hold_nxt = s1_hold_r;
    end else if (spi_en_r) begin
      res_valid = 1'b1;
      if (cmd_r == CMD_NONE) begin
        cmd_nxt  = s1_tx_r;
        addr_nxt = '0;
        left_nxt = ADDR_BYTES;
      end else if (left_r != 2'd0) begin
        addr_nxt = {addr_r[ADDR_W-BYTE_W-1:0], s1_tx_r};
        left_nxt = left_r - 2'd1;
      end else begin
        unique case (cmd_r)
          CMD_WR: begin
            wr_hit   = 1'b1;
            addr_nxt = ADDR_W'(idx_inc);
          end
          CMD_RD: begin
            res_rd   = 1'b1;
            addr_nxt = ADDR_W'(idx_inc);
          end
          CMD_WRDI: wel_nxt = 1'b0;
          CMD_RDSR: res_rx = {6'd0, wel_r, 1'b0};
          CMD_WREN: wel_nxt = 1'b1;
          default: ;
        endcase
      end
    end
  end

  assign ram_we    = clr_busy_r | (s1_fire & wr_hit);
  assign ram_waddr = clr_busy_r ? clr_addr_r : flash_idx;
  assign ram_wdata = clr_busy_r ? '0 : s1_tx_r;
  assign ram_re    = s1_fire & res_rd;

  ssf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FLASH_DEPTH)
  ) u_flash (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (flash_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spi_en_r    <= 1'b0;
      irq_en_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
      cmd_r       <= CMD_NONE;
      addr_r      <= '0;
      left_r      <= 2'd0;
      wel_r       <= 1'b0;
      hold_r      <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_SPI_EN: spi_en_r <= cfg_wdata;
          CFG_IRQ_EN: irq_en_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_fire) begin
        cmd_r  <= cmd_nxt;
        addr_r <= addr_nxt;
        left_r <= left_nxt;
        wel_r  <= wel_nxt;
        hold_r <= hold_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_fire & res_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tuser;
      s1_tx_r   <= in_tdata[7:0];
      s1_hold_r <= in_tdata[8];
    end
    if (out_free) begin
      rx_r     <= res_rx;
      rd_sel_r <= res_rd;
      irq_r    <= irq_en_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, irq_r, (rd_sel_r ? ram_rdata : rx_r)};

  // no item enters while the flash is being cleared
  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_tready && !s1_valid_r)
    else $error("item taken during flash clear");

  // a control write never produces a result
  a_ctrl_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_op_r == OP_CTRL) |=> !out_valid_r)
    else $error("result from control write");

  // status latch, command and address move only when an item is processed
  a_wel_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(wel_r) && $stable(cmd_r) && $stable(addr_r))
    else $error("state changed without an item");

  // flash access only once the address phase is done
  a_flash_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_re || (ram_we && !clr_busy_r)) |-> left_r == 2'd0 && cmd_r != CMD_NONE)
    else $error("flash access outside data phase");

endmodule
